FILE: hdl/bid_pkg.sv
// ----------------------------------------------------------------------------
// bid_pkg: shared types and constants of the bilinear downscaler
// Configuration record, blend job record, register indexes and defaults.
// ----------------------------------------------------------------------------
package bid_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_W     = 29;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CH_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_W   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_H   = 3'd6;

  // geometry widths
  localparam int DIM_W = 16;
  localparam int ACC_W = 32;
  localparam int PIX_W = 32;
  localparam int CHANS = 4;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [12:0] source_width;
    logic [15:0] source_height;
    logic [12:0] max_dimension;
    logic [2:0]  channel_count;
    logic [28:0] step_q16;
    logic [12:0] output_width;
    logic [15:0] output_height;
  } bid_cfg_t;

  // four neighbors and flags of one output pixel
  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p11;
    logic             row_end;
    logic             frame_end;
    logic [CHANS-1:0] chan_mask;
  } bid_job_t;

endpackage

FILE: hdl/bid_ifs.sv
// ----------------------------------------------------------------------------
// bid_ifs: stream channels of the bilinear downscaler
// Source pixel channel and result pixel channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bid_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;
  logic [7:0] chan3_in;
  logic       frame_start;

  modport source (output valid, chan0_in, chan1_in, chan2_in, chan3_in, frame_start,
                  input ready);
  modport sink (input valid, chan0_in, chan1_in, chan2_in, chan3_in, frame_start,
                output ready);
endinterface

interface bid_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0_out;
  logic [7:0] chan1_out;
  logic [7:0] chan2_out;
  logic [7:0] chan3_out;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, chan0_out, chan1_out, chan2_out, chan3_out, row_end,
                  frame_end, input ready);
  modport sink (input valid, chan0_out, chan1_out, chan2_out, chan3_out, row_end,
                frame_end, output ready);
endinterface

FILE: hdl/bilinear_image_downscaler.sv
// ----------------------------------------------------------------------------
// bilinear_image_downscaler: streaming bilinear downscaler, top level
// Configuration registers, pixel front end, job queue and blend back end.
//
//   channel   dir   handshake       payload
//   pix_in    in    valid/ready     chan0_in..chan3_in, frame_start
//   res_out   out   valid/ready     chan0_out..chan3_out, row_end, frame_end
//   cfg       in    cfg_we          cfg_index, cfg_data
//
// In the front end each source pixel reads the line buffer entry of its
// column at acceptance, then decides and writes it back.
// A queued job passes the weight-product stage, then the output register.
// The queue and the output register let the front keep accepting while
// res_out is stalled, until the queue fills.
// Reset is synchronous; no clearing pass, the line buffer entries read in the
// first row of a frame are not used.
// ----------------------------------------------------------------------------
module bilinear_image_downscaler #(
  parameter int MAX_WIDTH = bid_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = bid_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bid_pkg::CFG_W-1:0]      cfg_data,
  bid_pix_if.sink                        pix_in,
  bid_res_if.source                      res_out
);
  import bid_pkg::*;

  localparam int QW = $bits(bid_job_t) + 2 * FRAC_BITS;

  bid_cfg_t              cfg;
  bid_job_t              job;
  logic [FRAC_BITS-1:0]  job_tx, job_ty;
  logic                  q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]         q_dout;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= 13'd1;
      cfg.source_height <= 16'd1;
      cfg.max_dimension <= 13'd4096;
      cfg.channel_count <= 3'd4;
      cfg.step_q16      <= 29'd65536;
      cfg.output_width  <= 13'd1;
      cfg.output_height <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W:   cfg.source_width  <= cfg_data[12:0];
        REG_SRC_H:   cfg.source_height <= cfg_data[15:0];
        REG_MAX_DIM: cfg.max_dimension <= cfg_data[12:0];
        REG_CH_CNT:  cfg.channel_count <= cfg_data[2:0];
        REG_STEP:    cfg.step_q16      <= cfg_data[28:0];
        REG_OUT_W:   cfg.output_width  <= cfg_data[12:0];
        REG_OUT_H:   cfg.output_height <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  bid_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pix_in (pix_in),
    .push   (q_push),
    .job    (job),
    .job_tx (job_tx),
    .job_ty (job_ty),
    .q_full (q_full)
  );

  bid_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({job, job_tx, job_ty}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  bid_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_dout),
    .pop     (q_pop),
    .res_out (res_out)
  );

  // one item in the front end at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> !pix_in.ready)
    else $error("front accepted a second item while busy");

  // back end only pops a queue that holds a job
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

  // a frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.frame_end |-> res_out.row_end)
    else $error("frame end without row end");

endmodule

FILE: hdl/bid_ram.sv
// ----------------------------------------------------------------------------
// bid_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bid_queue.sv
// ----------------------------------------------------------------------------
// bid_queue: short job queue
// Decouples the pixel front end from the blend back end.
// ----------------------------------------------------------------------------
module bid_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule

FILE: hdl/bid_front.sv
// ----------------------------------------------------------------------------
// bid_front: pixel front end of the bilinear downscaler
// Accepts source pixels, tracks position, keeps the line buffer, builds blend
// jobs for sample points' lower-right neighbors, or for each pixel in pass.
// ----------------------------------------------------------------------------
module bid_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bid_pkg::bid_cfg_t     cfg,
  bid_pix_if.sink               pix_in,
  output logic                  push,
  output bid_pkg::bid_job_t     job,
  output logic [FRAC_BITS-1:0]  job_tx,
  output logic [FRAC_BITS-1:0]  job_ty,
  input  logic                  q_full
);
  import bid_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [28:0] ONE = 29'(64'(1) << FRAC_BITS);

  typedef enum logic {S_IDLE, S_WORK} state_t;

  state_t            state;
  logic [AW-1:0]     col;
  logic [DIM_W-1:0]  row;
  logic [12:0]       ocol;
  logic [15:0]       orow;
  logic [ACC_W-1:0]  xacc;
  logic [ACC_W-1:0]  yacc;
  logic [PIX_W-1:0]  left_pixel;
  logic [PIX_W-1:0]  up_left;
  logic [PIX_W-1:0]  pix;
  logic [PIX_W-1:0]  up;

  logic [DIM_W-1:0]  w, h, md, wm1, hm1;
  logic [28:0]       step;
  logic              pass;
  logic [CHANS-1:0]  mask;
  logic              accept, done, emit, hit;

  logic [AW-1:0]     a_col;
  logic [DIM_W-1:0]  a_row;
  logic [12:0]       a_ocol;
  logic [15:0]       a_orow;
  logic [ACC_W-1:0]  a_x, a_y;
  logic [DIM_W:0]    a_rinc;

  logic [AW-1:0]     b_col;
  logic [DIM_W-1:0]  b_row;
  logic [12:0]       b_ocol;
  logic [15:0]       b_orow;
  logic [ACC_W-1:0]  b_x, b_y;
  logic [DIM_W:0]    b_rinc;
  logic [DIM_W-1:0]  c_inc;

  logic [32:0]       gx, gx1, gy, gy1;
  logic [DIM_W-1:0]  x0, x1, y0, y1, col16;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [28:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + (ACC_W + 1)'(b);
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  // effective geometry from the registers
  always_comb begin
    if (cfg.source_width == '0) begin
      w = 16'd1;
    end else if (16'(cfg.source_width) > 16'(MAX_WIDTH)) begin
      w = 16'(MAX_WIDTH);
    end else begin
      w = 16'(cfg.source_width);
    end
    h    = (cfg.source_height == '0) ? 16'd1 : cfg.source_height;
    md   = (cfg.max_dimension == '0) ? 16'd1 : 16'(cfg.max_dimension);
    step = (cfg.step_q16 < ONE) ? ONE : cfg.step_q16;
    pass = (w <= md) && (h <= md);
    for (int c = 0; c < CHANS; c++) begin
      mask[c] = (cfg.channel_count > 3'(c));
    end
  end

  assign wm1 = w - 16'd1;
  assign hm1 = h - 16'd1;

  assign pix_in.ready = (state == S_IDLE);
  assign accept       = pix_in.valid && pix_in.ready;

  // position at acceptance: frame start, row wrap, frame wrap
  always_comb begin
    a_col  = col;
    a_row  = row;
    a_ocol = ocol;
    a_orow = orow;
    a_x    = xacc;
    a_y    = yacc;
    if (pix_in.frame_start) begin
      a_col  = '0;
      a_row  = '0;
      a_ocol = '0;
      a_orow = '0;
      a_x    = '0;
      a_y    = '0;
    end
    a_rinc = {1'b0, a_row};
    if (16'(a_col) >= w) begin
      a_col  = '0;
      a_rinc = {1'b0, a_row} + 17'd1;
    end
    a_row = a_rinc[DIM_W-1:0];
    if (a_rinc >= {1'b0, h}) begin
      a_col  = '0;
      a_row  = '0;
      a_ocol = '0;
      a_orow = '0;
      a_x    = '0;
      a_y    = '0;
    end
  end

  // sample point neighbors, clamped to the frame
  always_comb begin
    col16 = 16'(col);
    gx    = 33'(xacc >> FRAC_BITS);
    gy    = 33'(yacc >> FRAC_BITS);
    gx1   = gx + 33'd1;
    gy1   = gy + 33'd1;
    x0    = (gx  > 33'(wm1)) ? wm1 : gx[DIM_W-1:0];
    x1    = (gx1 > 33'(wm1)) ? wm1 : gx1[DIM_W-1:0];
    y0    = (gy  > 33'(hm1)) ? hm1 : gy[DIM_W-1:0];
    y1    = (gy1 > 33'(hm1)) ? hm1 : gy1[DIM_W-1:0];
    hit   = !pass && (orow < cfg.output_height) && (ocol < cfg.output_width) &&
            (x1 == col16) && (y1 == row);
    emit  = pass || hit;
  end

  // blend job
  always_comb begin
    job.chan_mask = mask;
    if (pass) begin
      job.p00       = pix;
      job.p10       = pix;
      job.p01       = pix;
      job.p11       = pix;
      job_tx        = '0;
      job_ty        = '0;
      job.row_end   = (col16 == wm1);
      job.frame_end = (col16 == wm1) && (row == hm1);
    end else begin
      job.p11       = pix;
      job.p01       = (x0 == x1) ? pix : left_pixel;
      job.p10       = (y0 == y1) ? pix : up;
      job.p00       = (y0 == y1) ? job.p01 : ((x0 == x1) ? up : up_left);
      job_tx        = xacc[FRAC_BITS-1:0];
      job_ty        = yacc[FRAC_BITS-1:0];
      job.row_end   = (14'(ocol) + 14'd1 == 14'(cfg.output_width));
      job.frame_end = job.row_end && (17'(orow) + 17'd1 == 17'(cfg.output_height));
    end
  end

  assign push = (state == S_WORK) && emit && !q_full;
  assign done = (state == S_WORK) && (!emit || !q_full);

  // position after the item
  always_comb begin
    b_col  = col;
    b_row  = row;
    b_ocol = ocol;
    b_orow = orow;
    b_x    = xacc;
    b_y    = yacc;
    b_rinc = {1'b0, row};
    if (hit) begin
      b_ocol = ocol + 13'd1;
      b_x    = sat_add(xacc, step);
    end
    c_inc = col16 + 16'd1;
    if (c_inc >= w) begin
      b_col = '0;
      if (!pass && (orow < cfg.output_height) && (y1 <= row)) begin
        b_orow = orow + 16'd1;
        b_y    = sat_add(yacc, step);
      end
      b_ocol = '0;
      b_x    = '0;
      b_rinc = {1'b0, row} + 17'd1;
      b_row  = b_rinc[DIM_W-1:0];
      if (b_rinc >= {1'b0, h}) begin
        b_row  = '0;
        b_ocol = '0;
        b_orow = '0;
        b_x    = '0;
        b_y    = '0;
      end
    end else begin
      b_col = c_inc[AW-1:0];
    end
  end

  // line buffer: read at acceptance, written when the item completes
  bid_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (done),
    .waddr (col),
    .wdata (pix),
    .re    (accept),
    .raddr (a_col),
    .rdata (up)
  );

  // sequencer and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      col        <= '0;
      row        <= '0;
      ocol       <= '0;
      orow       <= '0;
      xacc       <= '0;
      yacc       <= '0;
      left_pixel <= '0;
      up_left    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WORK;
            col   <= a_col;
            row   <= a_row;
            ocol  <= a_ocol;
            orow  <= a_orow;
            xacc  <= a_x;
            yacc  <= a_y;
            pix   <= {pix_in.chan3_in, pix_in.chan2_in, pix_in.chan1_in, pix_in.chan0_in};
          end
        end
        S_WORK: begin
          if (done) begin
            state      <= S_IDLE;
            col        <= b_col;
            row        <= b_row;
            ocol       <= b_ocol;
            orow       <= b_orow;
            xacc       <= b_x;
            yacc       <= b_y;
            left_pixel <= pix;
            up_left    <= up;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/bid_back.sv
// ----------------------------------------------------------------------------
// bid_back: blend back end of the bilinear downscaler
// Weight products in one stage, per-channel weighted sums and clamp in the
// next, into the output register.
// ----------------------------------------------------------------------------
module bid_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         q_valid,
  input  logic [$bits(bid_pkg::bid_job_t)+2*FRAC_BITS-1:0] q_data,
  output logic                                         pop,
  bid_res_if.source                                    res_out
);
  import bid_pkg::*;

  localparam int WW = FRAC_BITS + 1;
  localparam int PW = 2 * FRAC_BITS + 2;
  localparam int VW = 2 * FRAC_BITS + 11;
  localparam logic [WW-1:0] ONE = WW'(64'(1) << FRAC_BITS);

  bid_job_t              qj;
  logic [FRAC_BITS-1:0]  tx, ty;
  logic [WW-1:0]         wx0, wy0;

  logic                  s1_valid;
  bid_job_t              s1_job;
  logic [PW-1:0]         s1_w00, s1_w10, s1_w01, s1_w11;

  logic                  out_valid;
  logic                  out_take, s1_free;
  logic [7:0]            blend [CHANS];
  logic [7:0]            out_ch [CHANS];
  logic                  out_re, out_fe;
  logic [VW-1:0]         v;
  logic [VW-1:0]         vs;

  assign {qj, tx, ty} = q_data;
  assign wx0 = ONE - {1'b0, tx};
  assign wy0 = ONE - {1'b0, ty};

  assign out_take = s1_valid && (!out_valid || res_out.ready);
  assign s1_free  = !s1_valid || out_take;
  assign pop      = q_valid && s1_free;

  // per-channel weighted sum, truncate and clamp
  always_comb begin
    v  = '0;
    vs = '0;
    for (int c = 0; c < CHANS; c++) begin
      v  = VW'(s1_job.p00[8*c +: 8]) * VW'(s1_w00) +
           VW'(s1_job.p10[8*c +: 8]) * VW'(s1_w10) +
           VW'(s1_job.p01[8*c +: 8]) * VW'(s1_w01) +
           VW'(s1_job.p11[8*c +: 8]) * VW'(s1_w11);
      vs = v >> (2 * FRAC_BITS);
      if (!s1_job.chan_mask[c]) begin
        blend[c] = 8'd0;
      end else if (vs > VW'(255)) begin
        blend[c] = 8'hFF;
      end else begin
        blend[c] = vs[7:0];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= q_valid;
      end
      if (out_take) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // weight products and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_job <= qj;
      s1_w00 <= PW'(wx0 * wy0);
      s1_w10 <= PW'({1'b0, tx} * wy0);
      s1_w01 <= PW'(wx0 * {1'b0, ty});
      s1_w11 <= PW'({1'b0, tx} * {1'b0, ty});
    end
    if (out_take) begin
      out_ch <= blend;
      out_re <= s1_job.row_end;
      out_fe <= s1_job.frame_end;
    end
  end

  assign res_out.valid     = out_valid;
  assign res_out.chan0_out = out_ch[0];
  assign res_out.chan1_out = out_ch[1];
  assign res_out.chan2_out = out_ch[2];
  assign res_out.chan3_out = out_ch[3];
  assign res_out.row_end   = out_re;
  assign res_out.frame_end = out_fe;

endmodule
